### src/two_electron_fock_accumulator_defines.svh
// Assertion macros for the two-electron Fock accumulator.
`ifndef TWO_ELECTRON_FOCK_ACCUMULATOR_DEFINES_SVH
`define TWO_ELECTRON_FOCK_ACCUMULATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define TEFA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define TEFA_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define TEFA_ASSERT(label, prop, msg)
`define TEFA_ASSERT_RST(label, prop, msg)
`endif
`endif

### src/tefa_pkg.sv
// Shared constants and types for the two-electron Fock accumulator.
package tefa_pkg;
    localparam int ORBITALS      = 64;
    localparam int FRACTION_BITS = 40;
    localparam int DEPTH         = (ORBITALS * (ORBITALS + 1)) / 2;
    localparam int IDXW          = $clog2(DEPTH);
    localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } t_mul_req;

    typedef struct packed {
        logic        done;
        logic        ovf;
        logic [63:0] result;
    } t_mul_rsp;
endpackage

### src/tefa_fxmul.sv
// Iterative signed fixed-point multiplier on one shared 32x32 multiplier.
module tefa_fxmul import tefa_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);
    typedef enum logic [1:0] {M_IDLE, M_MUL, M_RND, M_SAT} t_mstate;

    localparam logic [127:0] HALF = 128'(1) << (FRACTION_BITS - 1);

    t_mstate       r_state;
    logic [63:0]   r_ma, r_mb;
    logic          r_neg;
    logic [127:0]  r_acc;
    logic [1:0]    r_cnt;
    logic          r_done, r_ovf;
    logic [63:0]   r_res;

    logic [31:0]   w_ha, w_hb;
    logic [63:0]   w_p;
    logic [1:0]    w_sh;
    logic [127:0]  w_q;

    assign w_ha = r_cnt[1] ? r_ma[63:32] : r_ma[31:0];
    assign w_hb = r_cnt[0] ? r_mb[63:32] : r_mb[31:0];
    assign w_p  = 64'(w_ha) * 64'(w_hb);
    assign w_sh = 2'({1'b0, r_cnt[1]} + {1'b0, r_cnt[0]});
    assign w_q  = r_acc >> FRACTION_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                M_IDLE: begin
                    if (i_req.start) begin
                        r_ma    <= i_req.a[63] ? (64'd0 - i_req.a) : i_req.a;
                        r_mb    <= i_req.b[63] ? (64'd0 - i_req.b) : i_req.b;
                        r_neg   <= i_req.a[63] ^ i_req.b[63];
                        r_acc   <= '0;
                        r_cnt   <= '0;
                        r_state <= M_MUL;
                    end
                end
                M_MUL: begin
                    r_acc <= r_acc + (128'(w_p) << {w_sh, 5'b0});
                    r_cnt <= r_cnt + 2'd1;
                    if (r_cnt == 2'd3) begin
                        r_state <= M_RND;
                    end
                end
                M_RND: begin
                    r_acc   <= r_acc + HALF;
                    r_state <= M_SAT;
                end
                M_SAT: begin
                    if (r_neg) begin
                        if (w_q[127:64] != '0 || w_q[63:0] > SMIN) begin
                            r_ovf <= 1'b1;
                            r_res <= SMIN;
                        end else begin
                            r_ovf <= 1'b0;
                            r_res <= 64'd0 - w_q[63:0];
                        end
                    end else begin
                        if (w_q[127:64] != '0 || w_q[63]) begin
                            r_ovf <= 1'b1;
                            r_res <= SMAX;
                        end else begin
                            r_ovf <= 1'b0;
                            r_res <= w_q[63:0];
                        end
                    end
                    r_done  <= 1'b1;
                    r_state <= M_IDLE;
                end
                default: r_state <= M_IDLE;
            endcase
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.ovf    = r_ovf;
    assign o_rsp.result = r_res;
endmodule

### src/two_electron_fock_accumulator.sv
// Top level: packed density and Fock accumulator stores with integral sequencer.
// An item is taken when start is high and busy is low; results cannot be held off.
// Density and accumulator loads never raise busy. An accumulator read result is
// registered from the store and shows on o_read_data for one cycle under o_valid.
// An integral keeps busy high until it is done or ignored after its checks: four
// triangle-number steps, one step of index forming and checks, six density reads
// each through the shared fixed-point multiplier (four 32x32 partial products,
// rounding and saturation), up to four saturating doublings on the shared adder,
// then nine update slots on the accumulator store: each applied slot does a
// read-modify-write in S_URD and S_UWR; a slot the symmetry rules skip passes S_URD only.
`include "two_electron_fock_accumulator_defines.svh"
module two_electron_fock_accumulator import tefa_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_kind,
    input  logic [11:0]        i_entry_index,
    input  logic signed [63:0] i_value,
    input  logic [5:0]         i_orb_i,
    input  logic [5:0]         i_orb_j,
    input  logic [5:0]         i_orb_k,
    input  logic [5:0]         i_orb_l,
    output logic               o_valid,
    output logic signed [63:0] o_read_data,
    output logic               o_overflow_seen
);
    typedef enum logic [3:0] {
        S_IDLE, S_RESP, S_TRI, S_IDX, S_DRD, S_DMUL, S_DWAIT, S_DBL, S_URD, S_UWR
    } t_state;

    localparam logic [1:0] K_LD_DEN = 2'd0;
    localparam logic [1:0] K_LD_ACC = 2'd1;
    localparam logic [1:0] K_INT    = 2'd2;
    localparam logic [1:0] K_RD_ACC = 2'd3;

    function automatic logic [64:0] sat_as(logic [63:0] a, logic [63:0] b, logic sub);
        logic [63:0] s;
        logic [63:0] x;
        s = sub ? (a - b) : (a + b);
        x = sub ? ((a ^ b) & (a ^ s)) : ((a ^ s) & (b ^ s));
        return {x[63], x[63] ? (a[63] ? SMIN : SMAX) : s};
    endfunction

    logic [63:0] den_mem [DEPTH];
    logic [63:0] acc_mem [DEPTH];

    t_state      r_state;
    logic        r_ovf;
    logic        r_rd_ok;
    logic [63:0] r_val;
    logic [5:0]  r_oi, r_oj, r_ok, r_ol;
    logic [IDXW-1:0] r_ti, r_tj, r_tk, r_tl;
    logic [IDXW-1:0] r_ij, r_kl, r_ik, r_il, r_jk, r_jl;
    logic        r_ineq, r_kneq, r_ijneq, r_jgek, r_jgel, r_ilek, r_jlel, r_jlek;
    logic [63:0] r_da, r_db, r_sjl, r_sjk, r_sik, r_sil;
    logic [1:0]  r_tstep, r_bstep;
    logic [2:0]  r_dstep;
    logic [3:0]  r_ustep;
    logic [63:0] r_den_rd, r_acc_rd;

    t_mul_req    w_mreq;
    t_mul_rsp    w_mrsp;
    logic        w_take, w_in_range;
    logic [IDXW-1:0] w_ent;
    logic [5:0]  w_tn;
    logic [IDXW:0] w_tn_ext, w_tprod;
    logic [IDXW-1:0] w_ij, w_kl, w_ik, w_il, w_jk, w_jl;
    logic [IDXW-1:0] w_den_ra, w_acc_ra, w_acc_wa;
    logic        w_acc_we, w_den_we;
    logic [63:0] w_acc_wd;
    logic        w_op_en, w_op_sub;
    logic [IDXW-1:0] w_op_addr;
    logic [63:0] w_op_val;
    logic [63:0] w_add_a, w_add_b;
    logic        w_add_sub;
    logic [64:0] w_sum;

    tefa_fxmul u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_mreq),
        .o_rsp  (w_mrsp)
    );

    assign busy       = (r_state != S_IDLE);
    assign w_take     = start && !busy;
    assign w_ent      = IDXW'(i_entry_index);
    assign w_in_range = 32'(i_entry_index) < DEPTH;

    always_comb begin
        unique case (r_tstep)
            2'd0:    w_tn = r_oi;
            2'd1:    w_tn = r_oj;
            2'd2:    w_tn = r_ok;
            default: w_tn = r_ol;
        endcase
    end
    assign w_tn_ext = (IDXW + 1)'(w_tn);
    assign w_tprod  = (IDXW + 1)'(w_tn_ext * (w_tn_ext + 1'b1));

    assign w_ij = r_ti + IDXW'(r_oj);
    assign w_kl = r_tk + IDXW'(r_ol);
    assign w_ik = r_ti + IDXW'(r_ok);
    assign w_il = r_ti + IDXW'(r_ol);
    assign w_jk = (r_oj > r_ok) ? (r_tj + IDXW'(r_ok)) : (r_tk + IDXW'(r_oj));
    assign w_jl = (r_oj > r_ol) ? (r_tj + IDXW'(r_ol)) : (r_tl + IDXW'(r_oj));

    always_comb begin
        unique case (r_dstep)
            3'd0:    w_den_ra = r_ij;
            3'd1:    w_den_ra = r_kl;
            3'd2:    w_den_ra = r_ik;
            3'd3:    w_den_ra = r_il;
            3'd4:    w_den_ra = r_jl;
            default: w_den_ra = r_jk;
        endcase
    end

    always_comb begin
        w_op_en   = 1'b0;
        w_op_sub  = 1'b1;
        w_op_addr = r_ik;
        w_op_val  = r_sik;
        unique case (r_ustep)
            4'd0: begin
                w_op_en = r_kneq;
            end
            4'd1: begin
                w_op_en = r_kneq && r_ineq && r_jgek; w_op_addr = r_jk; w_op_val = r_sjk;
            end
            4'd2: begin
                w_op_en = 1'b1; w_op_addr = r_il; w_op_val = r_sil;
            end
            4'd3: begin
                w_op_en = 1'b1; w_op_sub = 1'b0; w_op_addr = r_ij; w_op_val = r_db;
            end
            4'd4: begin
                w_op_en = r_ineq && r_jgel; w_op_addr = r_jl; w_op_val = r_sjl;
            end
            4'd5: begin
                w_op_en = r_ijneq && r_jlek; w_op_addr = r_jk; w_op_val = r_sjk;
            end
            4'd6: begin
                w_op_en = r_ijneq && r_jlek && r_ineq && r_ilek;
            end
            4'd7: begin
                w_op_en = r_ijneq && r_jlek && r_kneq && r_jlel;
                w_op_addr = r_jl; w_op_val = r_sjl;
            end
            4'd8: begin
                w_op_en = r_ijneq; w_op_sub = 1'b0; w_op_addr = r_kl; w_op_val = r_da;
            end
            default: w_op_en = 1'b0;
        endcase
    end

    always_comb begin
        if (r_state == S_DBL) begin
            w_add_a   = (r_bstep[0] ^ r_bstep[1]) ? r_db : r_da;
            w_add_b   = w_add_a;
            w_add_sub = 1'b0;
        end else begin
            w_add_a   = r_acc_rd;
            w_add_b   = w_op_val;
            w_add_sub = w_op_sub;
        end
    end
    assign w_sum = sat_as(w_add_a, w_add_b, w_add_sub);

    assign w_den_we = w_take && (i_kind == K_LD_DEN) && w_in_range;
    assign w_acc_ra = (r_state == S_IDLE) ? w_ent : w_op_addr;
    always_comb begin
        if (r_state == S_UWR) begin
            w_acc_we = 1'b1;
            w_acc_wa = w_op_addr;
            w_acc_wd = w_sum[63:0];
        end else begin
            w_acc_we = w_take && (i_kind == K_LD_ACC) && w_in_range;
            w_acc_wa = w_ent;
            w_acc_wd = i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_den_we) begin
            den_mem[w_ent] <= i_value;
        end
        r_den_rd <= den_mem[w_den_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_acc_we) begin
            acc_mem[w_acc_wa] <= w_acc_wd;
        end
        r_acc_rd <= acc_mem[w_acc_ra];
    end

    assign w_mreq.start = (r_state == S_DMUL);
    assign w_mreq.a     = r_val;
    assign w_mreq.b     = r_den_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovf   <= 1'b0;
            r_tstep <= '0;
            r_dstep <= '0;
            r_bstep <= '0;
            r_ustep <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        r_rd_ok <= w_in_range;
                        r_val   <= i_value;
                        r_oi    <= i_orb_i;
                        r_oj    <= i_orb_j;
                        r_ok    <= i_orb_k;
                        r_ol    <= i_orb_l;
                        r_tstep <= '0;
                        if (i_kind == K_RD_ACC) begin
                            r_state <= S_RESP;
                        end else if (i_kind == K_INT) begin
                            r_state <= S_TRI;
                        end
                    end
                end
                S_RESP: r_state <= S_IDLE;
                S_TRI: begin
                    unique case (r_tstep)
                        2'd0:    r_ti <= IDXW'(w_tprod >> 1);
                        2'd1:    r_tj <= IDXW'(w_tprod >> 1);
                        2'd2:    r_tk <= IDXW'(w_tprod >> 1);
                        default: r_tl <= IDXW'(w_tprod >> 1);
                    endcase
                    r_tstep <= r_tstep + 2'd1;
                    if (r_tstep == 2'd3) begin
                        r_state <= S_IDX;
                    end
                end
                S_IDX: begin
                    r_ij    <= w_ij;
                    r_kl    <= w_kl;
                    r_ik    <= w_ik;
                    r_il    <= w_il;
                    r_jk    <= w_jk;
                    r_jl    <= w_jl;
                    r_ineq  <= r_oi != r_oj;
                    r_kneq  <= r_ok != r_ol;
                    r_ijneq <= w_ij != w_kl;
                    r_jgek  <= r_oj >= r_ok;
                    r_jgel  <= r_oj >= r_ol;
                    r_ilek  <= r_oi <= r_ok;
                    r_jlel  <= r_oj <= r_ol;
                    r_jlek  <= r_oj <= r_ok;
                    r_dstep <= '0;
                    if (32'(r_oi) >= ORBITALS || 32'(r_oj) >= ORBITALS ||
                        32'(r_ok) >= ORBITALS || 32'(r_ol) >= ORBITALS ||
                        r_oj > r_oi || r_ol > r_ok || w_ij < w_kl) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_DRD;
                    end
                end
                S_DRD:  r_state <= S_DMUL;
                S_DMUL: r_state <= S_DWAIT;
                S_DWAIT: begin
                    if (w_mrsp.done) begin
                        if (w_mrsp.ovf) begin
                            r_ovf <= 1'b1;
                        end
                        unique case (r_dstep)
                            3'd0:    r_da  <= w_mrsp.result;
                            3'd1:    r_db  <= w_mrsp.result;
                            3'd2:    r_sjl <= w_mrsp.result;
                            3'd3:    r_sjk <= w_mrsp.result;
                            3'd4:    r_sik <= w_mrsp.result;
                            default: r_sil <= w_mrsp.result;
                        endcase
                        r_dstep <= r_dstep + 3'd1;
                        r_bstep <= '0;
                        r_state <= (r_dstep == 3'd5) ? S_DBL : S_DRD;
                    end
                end
                S_DBL: begin
                    // steps: da, db, db again if k!=l, da again if ij!=kl and i!=j
                    if (r_bstep == 2'd0 || r_bstep == 2'd1 ||
                        (r_bstep == 2'd2 && r_kneq) ||
                        (r_bstep == 2'd3 && r_ijneq && r_ineq)) begin
                        if (r_bstep[0] ^ r_bstep[1]) begin
                            r_db <= w_sum[63:0];
                        end else begin
                            r_da <= w_sum[63:0];
                        end
                        if (w_sum[64]) begin
                            r_ovf <= 1'b1;
                        end
                    end
                    r_bstep <= r_bstep + 2'd1;
                    r_ustep <= '0;
                    if (r_bstep == 2'd3) begin
                        r_state <= S_URD;
                    end
                end
                S_URD: begin
                    if (w_op_en) begin
                        r_state <= S_UWR;
                    end else begin
                        r_ustep <= r_ustep + 4'd1;
                        if (r_ustep == 4'd8) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_UWR: begin
                    if (w_sum[64]) begin
                        r_ovf <= 1'b1;
                    end
                    r_ustep <= r_ustep + 4'd1;
                    r_state <= (r_ustep == 4'd8) ? S_IDLE : S_URD;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid         = (r_state == S_RESP);
    assign o_read_data     = r_rd_ok ? r_acc_rd : 64'd0;
    assign o_overflow_seen = r_ovf;

    `TEFA_ASSERT(a_strobe_single, o_valid |=> !o_valid, "result strobe held")
    `TEFA_ASSERT(a_ovf_sticky, r_ovf |=> r_ovf, "overflow flag cleared")
    `TEFA_ASSERT(a_mul_done_wait, w_mrsp.done |-> (r_state == S_DWAIT), "stray product")
    `TEFA_ASSERT_RST(a_idle_after_reset, !i_rst_n |=> !busy, "busy after reset")
endmodule
